>>> sv/vector3_normalize_top_assert.svh
// ----------------------------------------------------------------------------
// vector3_normalize_top_assert.svh
// assertion macros for the vector normalizer, clocked on i_clk
// ----------------------------------------------------------------------------
`ifndef VECTOR3_NORMALIZE_TOP_ASSERT_SVH
`define VECTOR3_NORMALIZE_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
// condition holds at every edge out of reset
`define VN_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("vector3_normalize: check failed");
// consequent holds in the same cycle as the antecedent
`define VN_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("vector3_normalize: implication failed");
`else
`define VN_ASSERT(lbl, cond)
`define VN_ASSERT_IMP(lbl, ante, cons)
`endif

`endif

>>> sv/vn_pkg.sv
// ----------------------------------------------------------------------------
// vn_pkg
// shared types and step functions for the vector normalizer
// ----------------------------------------------------------------------------
package vn_pkg;

    localparam int unsigned NUM_LANES  = 3;
    localparam int unsigned COMP_W     = 32;
    localparam int unsigned SQRT_STEPS = 32;
    localparam int unsigned DIV_STEPS  = 31;
    // per lane: absolute value plus sign
    localparam int unsigned SIDE_W     = NUM_LANES * (COMP_W + 1);

    // square root pipeline stage contents
    typedef struct packed {
        logic [33:0] rem;
        logic [31:0] root;
        logic [63:0] rad;
    } t_sq_st;

    // divider pipeline stage contents
    typedef struct packed {
        logic [31:0] rem;
        logic [30:0] num;
        logic [30:0] quo;
        logic [31:0] len;
        logic        neg;
    } t_div_st;

    // one restoring square root step, one result bit
    function automatic t_sq_st sqrt_step(t_sq_st s);
        t_sq_st      r;
        logic [35:0] t;
        logic [35:0] d;
        t     = {s.rem, s.rad[63:62]};
        d     = {2'b00, s.root, 2'b01};
        r.rad = {s.rad[61:0], 2'b00};
        if (t >= d) begin
            r.rem  = 34'(t - d);
            r.root = {s.root[30:0], 1'b1};
        end else begin
            r.rem  = t[33:0];
            r.root = {s.root[30:0], 1'b0};
        end
        return r;
    endfunction

    // one restoring division step, one quotient bit
    function automatic t_div_st div_step(t_div_st s);
        t_div_st     r;
        logic [32:0] t;
        t     = {s.rem, s.num[30]};
        r     = s;
        r.num = {s.num[29:0], 1'b0};
        if (t >= {1'b0, s.len}) begin
            r.rem = 32'(t - {1'b0, s.len});
            r.quo = {s.quo[29:0], 1'b1};
        end else begin
            r.rem = t[31:0];
            r.quo = {s.quo[29:0], 1'b0};
        end
        return r;
    endfunction

endpackage

>>> sv/vn_lane_sq.sv
// ----------------------------------------------------------------------------
// vn_lane_sq
// per-component lane front end: absolute value, then exact square
// ----------------------------------------------------------------------------
module vn_lane_sq (
    input  logic        i_clk,
    input  logic [31:0] i_comp,
    output logic [31:0] o_abs,
    output logic        o_neg,
    output logic [63:0] o_sq
);
    import vn_pkg::*;

    logic [31:0] r_abs1;
    logic        r_neg1;
    logic [31:0] r_abs2;
    logic        r_neg2;
    logic [63:0] r_sq2;

    // stage 1: magnitude and sign; the most negative value maps to 2^31
    always_ff @(posedge i_clk) begin
        r_neg1 <= i_comp[COMP_W-1];
        r_abs1 <= i_comp[COMP_W-1] ? (32'd0 - i_comp) : i_comp;
    end

    // stage 2: square
    always_ff @(posedge i_clk) begin
        r_abs2 <= r_abs1;
        r_neg2 <= r_neg1;
        r_sq2  <= {32'd0, r_abs1} * {32'd0, r_abs1};
    end

    assign o_abs = r_abs2;
    assign o_neg = r_neg2;
    assign o_sq  = r_sq2;
endmodule

>>> sv/vn_sqrt.sv
// ----------------------------------------------------------------------------
// vn_sqrt
// pipelined integer square root, one root bit per stage, with sideband
// ----------------------------------------------------------------------------
module vn_sqrt (
    input  logic                      i_clk,
    input  logic [63:0]               i_rad,
    input  logic [vn_pkg::SIDE_W-1:0] i_side,
    output logic [31:0]               o_root,
    output logic [vn_pkg::SIDE_W-1:0] o_side
);
    import vn_pkg::*;

    t_sq_st            r_st   [SQRT_STEPS];
    logic [SIDE_W-1:0] r_side [SQRT_STEPS];
    t_sq_st            w_in;

    assign w_in = '{rem: '0, root: '0, rad: i_rad};

    // one stage per root bit
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_stage
        if (k == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                r_st[k]   <= sqrt_step(w_in);
                r_side[k] <= i_side;
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                r_st[k]   <= sqrt_step(r_st[k-1]);
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_root = r_st[SQRT_STEPS-1].root;
    assign o_side = r_side[SQRT_STEPS-1];
endmodule

>>> sv/vn_lane_div.sv
// ----------------------------------------------------------------------------
// vn_lane_div
// per-component lane back end: pipelined divide of |c| * 2^30 by the length
// ----------------------------------------------------------------------------
module vn_lane_div (
    input  logic        i_clk,
    input  logic [31:0] i_abs,
    input  logic        i_neg,
    input  logic [31:0] i_len,
    output logic [31:0] o_unit,
    output logic [31:0] o_len
);
    import vn_pkg::*;

    t_div_st     r_st [DIV_STEPS];
    t_div_st     w_in;
    t_div_st     w_last;
    logic [31:0] w_quo;

    // high part of the dividend is below the length, so 31 quotient bits suffice
    assign w_in = '{rem: {1'b0, i_abs[31:1]}, num: {i_abs[0], 30'd0}, quo: '0,
                    len: i_len, neg: i_neg};

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_stage
        if (k == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                r_st[k] <= div_step(w_in);
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                r_st[k] <= div_step(r_st[k-1]);
            end
        end
    end

    // apply sign, force zero for a zero-length vector
    assign w_last = r_st[DIV_STEPS-1];
    assign w_quo  = {1'b0, w_last.quo};
    assign o_unit = (w_last.len == 32'd0) ? 32'd0 :
                    (w_last.neg ? (32'd0 - w_quo) : w_quo);
    assign o_len  = w_last.len;
endmodule

>>> sv/vector3_normalize_top.sv
// ----------------------------------------------------------------------------
// vector3_normalize_top
// 3D vector normalizer: Q15.16 in, unsigned Q16.16 length and Q1.30 unit vector out
// ----------------------------------------------------------------------------
// Input stream s_axis carries one vector per transfer (x, y, z in tdata).
// Output stream m_axis carries length and unit vector in tdata and the
// zero-vector flag in tuser. Three lanes square the components, a merge stage
// sums them, a 32-stage root pipeline finds the length and three 31-stage
// divider lanes form the unit components.
// Throughput: one vector per cycle while s_axis_tready is high. An input vector
// passes 66 pipeline stages, the first loaded at the transfer edge, then a
// result FIFO write and its registered read into the output register that
// drives m_axis_tvalid.
// The pipeline never stalls; results land in a FIFO of 2**FIFO_AW entries.
// s_axis_tready stays high while fewer than 2**FIFO_AW vectors are in flight
// or waiting, so a stalled receiver only fills the FIFO and input keeps
// flowing until that limit is reached.
// Reset empties the FIFO, drops all in-flight vectors and clears tvalid.
// ----------------------------------------------------------------------------
module vector3_normalize_top #(
    parameter int unsigned FIFO_AW = 7
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,  // comp_x, comp_y, comp_z
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,  // unit_x, unit_y, unit_z, magnitude
    output logic         m_axis_tuser   // zero_vector
);
    import vn_pkg::*;

    localparam int unsigned DEPTH   = 1 << FIFO_AW;
    localparam int unsigned PIPE_N  = 3 + SQRT_STEPS + DIV_STEPS;
    localparam int unsigned ENTRY_W = 129;

    logic                 w_in_xfer;
    logic                 w_out_xfer;
    logic [PIPE_N-1:0]    r_vld;
    logic [31:0]          w_abs  [NUM_LANES];
    logic                 w_neg  [NUM_LANES];
    logic [63:0]          w_sq   [NUM_LANES];
    logic [63:0]          r_sum;
    logic [SIDE_W-1:0]    r_side;
    logic [SIDE_W-1:0]    w_side_out;
    logic [31:0]          w_root;
    logic [31:0]          w_unit [NUM_LANES];
    logic [31:0]          w_len  [NUM_LANES];
    logic [ENTRY_W-1:0]   w_entry;
    logic [ENTRY_W-1:0]   r_mem [DEPTH];
    logic [FIFO_AW:0]     r_wr_ptr;
    logic [FIFO_AW:0]     r_rd_ptr;
    logic [FIFO_AW:0]     r_cnt;
    logic [FIFO_AW:0]     n_cnt;
    logic                 w_wr;
    logic                 w_pop;
    logic                 w_empty;
    logic                 w_full;
    logic                 r_ov;
    logic [ENTRY_W-1:0]   r_odata;

    assign w_in_xfer  = s_axis_tvalid && s_axis_tready;
    assign w_out_xfer = m_axis_tvalid && m_axis_tready;

    // valid tracking down the free-running pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[PIPE_N-2:0], w_in_xfer};
        end
    end

    // squaring lanes
    for (genvar l = 0; l < NUM_LANES; l++) begin : g_sq
        vn_lane_sq u_sq (
            .i_clk  (i_clk),
            .i_comp (s_axis_tdata[l*COMP_W +: COMP_W]),
            .o_abs  (w_abs[l]),
            .o_neg  (w_neg[l]),
            .o_sq   (w_sq[l])
        );
    end

    // merge: sum of squares, below 2^64 for any input
    always_ff @(posedge i_clk) begin
        r_sum  <= 64'({2'b00, w_sq[0]} + {2'b00, w_sq[1]} + {2'b00, w_sq[2]});
        r_side <= {w_neg[2], w_abs[2], w_neg[1], w_abs[1], w_neg[0], w_abs[0]};
    end

    vn_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_rad  (r_sum),
        .i_side (r_side),
        .o_root (w_root),
        .o_side (w_side_out)
    );

    // divider lanes
    for (genvar l = 0; l < NUM_LANES; l++) begin : g_div
        vn_lane_div u_div (
            .i_clk  (i_clk),
            .i_abs  (w_side_out[l*(COMP_W+1) +: COMP_W]),
            .i_neg  (w_side_out[l*(COMP_W+1) + COMP_W]),
            .i_len  (w_root),
            .o_unit (w_unit[l]),
            .o_len  (w_len[l])
        );
    end

    assign w_entry = {(w_len[0] == 32'd0), w_len[0], w_unit[2], w_unit[1], w_unit[0]};

    // result fifo
    assign w_wr    = r_vld[PIPE_N-1];
    assign w_empty = (r_wr_ptr == r_rd_ptr);
    assign w_full  = (r_wr_ptr[FIFO_AW] != r_rd_ptr[FIFO_AW]) &&
                     (r_wr_ptr[FIFO_AW-1:0] == r_rd_ptr[FIFO_AW-1:0]);
    assign w_pop   = !w_empty && (!r_ov || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr[FIFO_AW-1:0]] <= w_entry;
        end
        if (w_pop) begin
            r_odata <= r_mem[r_rd_ptr[FIFO_AW-1:0]];
        end
    end

    // pointers, output valid and in-flight count
    always_comb begin
        n_cnt = r_cnt;
        if (w_in_xfer && !w_out_xfer) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!w_in_xfer && w_out_xfer) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
                r_ov     <= 1'b1;
            end else if (w_out_xfer) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign s_axis_tready = (r_cnt < (FIFO_AW+1)'(DEPTH));
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_odata[127:0];
    assign m_axis_tuser  = r_odata[128];

    `include "vector3_normalize_top_assert.svh"

    `VN_ASSERT(a_cnt_bound, r_cnt <= (FIFO_AW+1)'(DEPTH))
    `VN_ASSERT_IMP(a_no_overflow, w_wr, !w_full)
    `VN_ASSERT_IMP(a_zero_units, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 128'd0)
endmodule

>>> dv/vector3_normalize_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector3_normalize_top_tb
// self-checking bench for the 3D vector normalizer
// ----------------------------------------------------------------------------
// Vectors are queued by an initial block and offered in bursts with random
// gaps; the output side stalls on its own pattern, with one long hold-off
// that backs up the result FIFO. Each output transfer is compared field by field
// against a length and unit vector computed in the bench.
// ----------------------------------------------------------------------------
module vector3_normalize_top_tb;

    typedef struct packed {
        logic [31:0] z;
        logic [31:0] y;
        logic [31:0] x;
    } t_vec;

    typedef struct packed {
        logic        zero;
        logic [31:0] mag;
        logic [31:0] uz;
        logic [31:0] uy;
        logic [31:0] ux;
    } t_norm;

    localparam int unsigned WATCHDOG_LIMIT = 20000;
    localparam int unsigned LATENCY        = 68;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [95:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;
    logic         m_axis_tuser;

    t_vec  pending_vecs[$];
    t_norm expected_norms[$];
    int    err_count = 0;
    int    idle_cycles = 0;
    int    burst_left = 0;
    int    gap_left = 0;
    int    hold_left = 0;
    bit    hold_done = 1'b0;
    int    accepted = 0;
    int    sent = 0;

    always #1 i_clk = ~i_clk;

    vector3_normalize_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // comp_x, comp_y, comp_z
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // unit_x, unit_y, unit_z, magnitude
        .m_axis_tuser  (m_axis_tuser)    // zero_vector
    );

    // bitwise integer square root, truncated
    function automatic logic [63:0] isqrt64(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = '0;
        b   = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // signed component over length, Q1.30, truncated toward zero
    function automatic logic [31:0] unit_comp(logic [31:0] c, logic [63:0] len);
        logic [63:0] mag;
        logic [63:0] q;
        mag = c[31] ? {32'd0, 32'(-c)} : {32'd0, c};
        if (c == 32'h8000_0000) mag = 64'h8000_0000;
        q = (mag << 30) / len;
        return c[31] ? 32'(-q) : q[31:0];
    endfunction

    function automatic t_norm normalize(t_vec v);
        t_norm       r;
        logic [63:0] ax, ay, az, len;
        ax  = v.x[31] ? 64'(-$signed({1'b1, v.x})) : 64'(v.x);
        ay  = v.y[31] ? 64'(-$signed({1'b1, v.y})) : 64'(v.y);
        az  = v.z[31] ? 64'(-$signed({1'b1, v.z})) : 64'(v.z);
        len = isqrt64(ax * ax + ay * ay + az * az);
        r   = '0;
        if (len == 0) begin
            r.zero = 1'b1;
        end else begin
            r.ux  = unit_comp(v.x, len);
            r.uy  = unit_comp(v.y, len);
            r.uz  = unit_comp(v.z, len);
            r.mag = len[31:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($signed($urandom_range(0, 200)) - 100);
            3: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            4: return 32'd0;
            default: return $urandom;
        endcase
    endfunction

    // sender: bursts and gaps, tvalid held until the offered vector is taken
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!s_axis_tvalid || accepted == sent) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_vecs.size() > 0) begin
                    s_axis_tdata  <= pending_vecs.pop_front();
                    s_axis_tvalid <= 1'b1;
                    sent++;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 30);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: full-ready and random-stall spans, one long hold-off once traffic is flowing
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!hold_done && accepted > 60) begin
                hold_done = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if ((accepted / 100) % 2 == 0) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    // input transfers feed the expectation queue
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            expected_norms.push_back(normalize(t_vec'(s_axis_tdata)));
            accepted++;
        end
    end

    // output check and watchdog
    always @(posedge i_clk) begin
        t_norm got;
        t_norm exp_n;
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tuser, m_axis_tdata};
                if (expected_norms.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    err_count++;
                end else begin
                    exp_n = expected_norms.pop_front();
                    if (got.ux !== exp_n.ux)
                        $display("%0t: unit_x exp %h got %h", $time, exp_n.ux, got.ux);
                    if (got.uy !== exp_n.uy)
                        $display("%0t: unit_y exp %h got %h", $time, exp_n.uy, got.uy);
                    if (got.uz !== exp_n.uz)
                        $display("%0t: unit_z exp %h got %h", $time, exp_n.uz, got.uz);
                    if (got.mag !== exp_n.mag)
                        $display("%0t: magnitude exp %h got %h", $time, exp_n.mag, got.mag);
                    if (got.zero !== exp_n.zero)
                        $display("%0t: zero_vector exp %b got %b", $time, exp_n.zero,
                                 got.zero);
                    if (got !== exp_n) err_count++;
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("vector3_normalize_top_tb failed");
                $finish;
            end
        end
    end

    initial begin
        t_vec v;
        int   wait_cnt;
        // directed: zero, extremes, axis-aligned, tiny lengths
        pending_vecs.push_back('{z: 32'd0, y: 32'd0, x: 32'd0});
        pending_vecs.push_back('{z: 32'h8000_0000, y: 32'h8000_0000, x: 32'h8000_0000});
        pending_vecs.push_back('{z: 32'h7fff_ffff, y: 32'h7fff_ffff, x: 32'h7fff_ffff});
        pending_vecs.push_back('{z: 32'd0, y: 32'd0, x: 32'h8000_0000});
        pending_vecs.push_back('{z: 32'd0, y: 32'd0, x: 32'h7fff_ffff});
        pending_vecs.push_back('{z: 32'd0, y: 32'h0001_0000, x: 32'd0});
        pending_vecs.push_back('{z: 32'hffff_0000, y: 32'd0, x: 32'd0});
        pending_vecs.push_back('{z: 32'd0, y: 32'd0, x: 32'd1});
        pending_vecs.push_back('{z: 32'hffff_ffff, y: 32'd0, x: 32'd0});
        pending_vecs.push_back('{z: 32'd1, y: 32'd1, x: 32'd1});
        pending_vecs.push_back('{z: 32'hffff_ffff, y: 32'hffff_ffff, x: 32'hffff_ffff});
        pending_vecs.push_back('{z: 32'h7fff_ffff, y: 32'h8000_0000, x: 32'd0});
        pending_vecs.push_back('{z: 32'h0003_0000, y: 32'h0004_0000, x: 32'h0000_0000});
        pending_vecs.push_back('{z: 32'h5555_5555, y: 32'haaaa_aaaa, x: 32'h0f0f_0f0f});
        for (int i = 0; i < 400; i++) begin
            v.x = rand_comp();
            v.y = rand_comp();
            v.z = rand_comp();
            pending_vecs.push_back(v);
        end

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (pending_vecs.size() > 0 || s_axis_tvalid) @(posedge i_clk);
        while (expected_norms.size() > 0) @(posedge i_clk);
        wait_cnt = 0;
        while (wait_cnt < LATENCY + 10) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        if (err_count == 0 && expected_norms.size() == 0) begin
            $display("vector3_normalize_top_tb passed");
        end else begin
            $display("vector3_normalize_top_tb failed");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+sv
sv/vn_pkg.sv
sv/vn_lane_sq.sv
sv/vn_sqrt.sv
sv/vn_lane_div.sv
sv/vector3_normalize_top.sv
dv/vector3_normalize_top_tb.sv
